>>> rtl/ecpsm_pkg.sv
// ----------------------------------------------------------------------------
// ecpsm_pkg
// Shared constants and types for the elliptic-curve scalar multiplier.
// ----------------------------------------------------------------------------
package ecpsm_pkg;

   localparam int WORD_BITS      = 64;
   localparam int TOP_BITS       = 3;
   localparam int IN_BITS        = 2 * WORD_BITS + TOP_BITS;
   localparam int FIELD_BITS_DEF = 131;
   localparam int CSR_IDX_BITS   = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_MOD_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MOD_MID  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MOD_HIGH = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_A_LOW    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_A_MID    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_A_HIGH   = 3'd5;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_INV = 2'd3;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } falu_req_type;

endpackage

>>> rtl/ecpsm_falu.sv
// ----------------------------------------------------------------------------
// ecpsm_falu
// Shared field unit: modular add and subtract with a registered result, multiply by
// double-and-add over the multiplier bits, inverse by square-and-multiply.
// ----------------------------------------------------------------------------
module ecpsm_falu
   import ecpsm_pkg::*;
#(
   parameter int FIELD_BITS = FIELD_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  falu_req_type          req,
   input  logic [FIELD_BITS-1:0] opa,
   input  logic [FIELD_BITS-1:0] opb,
   input  logic [FIELD_BITS-1:0] modulus,
   output logic                  done,
   output logic [FIELD_BITS-1:0] res
);

   localparam int CW = $clog2(FIELD_BITS);
   localparam logic [CW-1:0] TOP_BIT = CW'(FIELD_BITS - 1);
   localparam logic [FIELD_BITS-1:0] ONE = FIELD_BITS'(1);
   localparam logic [FIELD_BITS-1:0] TWO = FIELD_BITS'(2);

   localparam logic [1:0] AS_IDLE = 2'd0;
   localparam logic [1:0] AS_DBL  = 2'd1;
   localparam logic [1:0] AS_ADD  = 2'd2;
   localparam logic [1:0] AS_FIN  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic                  done_ff, done_in;
   logic                  inv_ff, inv_in;
   logic                  sqr_ff, sqr_in;
   logic [FIELD_BITS-1:0] res_ff, res_in;
   logic [FIELD_BITS-1:0] acc_ff, acc_in;
   logic [FIELD_BITS-1:0] ma_ff, ma_in;
   logic [FIELD_BITS-1:0] mb_ff, mb_in;
   logic [FIELD_BITS-1:0] base_ff, base_in;
   logic [FIELD_BITS-1:0] e_ff, e_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         j_ff, j_in;

   logic [FIELD_BITS-1:0] ad_x, ad_y, ad_r;
   logic                  ad_sub;
   logic [FIELD_BITS+1:0] s2, c2, pe;

   always_comb begin
      pe = {2'b00, modulus};
      s2 = ad_sub ? ({2'b00, ad_x} - {2'b00, ad_y}) : ({2'b00, ad_x} + {2'b00, ad_y});
      c2 = ad_sub ? (s2 + pe) : (s2 - pe);
      if (ad_sub) begin
         ad_r = s2[FIELD_BITS+1] ? c2[FIELD_BITS-1:0] : s2[FIELD_BITS-1:0];
      end else begin
         ad_r = c2[FIELD_BITS+1] ? s2[FIELD_BITS-1:0] : c2[FIELD_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      inv_in   = inv_ff;
      sqr_in   = sqr_ff;
      res_in   = res_ff;
      acc_in   = acc_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      base_in  = base_ff;
      e_in     = e_ff;
      cnt_in   = cnt_ff;
      j_in     = j_ff;
      ad_x     = acc_ff;
      ad_y     = acc_ff;
      ad_sub   = 1'b0;
      unique case (state_ff)
         AS_IDLE: begin
            ad_x   = opa;
            ad_y   = opb;
            ad_sub = (req.op == OP_SUB);
            if (req.start) begin
               unique case (req.op)
                  OP_ADD, OP_SUB: begin
                     res_in  = ad_r;
                     done_in = 1'b1;
                  end
                  OP_MUL: begin
                     ma_in    = opa;
                     mb_in    = opb;
                     acc_in   = '0;
                     cnt_in   = TOP_BIT;
                     inv_in   = 1'b0;
                     state_in = AS_DBL;
                  end
                  OP_INV: begin
                     base_in  = opa;
                     e_in     = modulus - TWO;
                     j_in     = TOP_BIT;
                     ma_in    = ONE;
                     mb_in    = ONE;
                     acc_in   = '0;
                     cnt_in   = TOP_BIT;
                     inv_in   = 1'b1;
                     sqr_in   = 1'b1;
                     state_in = AS_DBL;
                  end
                  default: ;
               endcase
            end
         end
         AS_DBL, AS_ADD: begin
            ad_y   = (state_ff == AS_ADD) ? ma_ff : acc_ff;
            acc_in = ad_r;
            if (state_ff == AS_DBL && mb_ff[cnt_ff]) begin
               state_in = AS_ADD;
            end else if (cnt_ff == '0) begin
               state_in = AS_FIN;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               state_in = AS_DBL;
            end
         end
         AS_FIN: begin
            if (!inv_ff) begin
               res_in   = acc_ff;
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end else if (sqr_ff && e_ff[j_ff]) begin
               ma_in    = acc_ff;
               mb_in    = base_ff;
               acc_in   = '0;
               cnt_in   = TOP_BIT;
               sqr_in   = 1'b0;
               state_in = AS_DBL;
            end else if (j_ff == '0) begin
               res_in   = acc_ff;
               done_in  = 1'b1;
               state_in = AS_IDLE;
            end else begin
               j_in     = j_ff - CW'(1);
               ma_in    = acc_ff;
               mb_in    = acc_ff;
               acc_in   = '0;
               cnt_in   = TOP_BIT;
               sqr_in   = 1'b1;
               state_in = AS_DBL;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      inv_ff  <= inv_in;
      sqr_ff  <= sqr_in;
      res_ff  <= res_in;
      acc_ff  <= acc_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      base_ff <= base_in;
      e_ff    <= e_in;
      cnt_ff  <= cnt_in;
      j_ff    <= j_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

>>> rtl/ec_point_scalar_multiply.sv
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply
// k*P on a short Weierstrass curve, right-to-left double-and-add, affine.
// ----------------------------------------------------------------------------
// A field multiply runs bit by bit on the shared modular adder; an inverse takes
// FIELD_BITS squarings and up to FIELD_BITS multiplies; a point operation one
// inverse and three or four multiplies; a scalar of n bits up to n adds and n-1
// doublings. A modulus below two or an input at infinity goes from idle straight
// to the output state, which raises the result strobe. One word in flight; busy
// stays high until the result strobe, which cannot be held off. Reset idles the
// sequencer and clears the CSRs to zero.
// ----------------------------------------------------------------------------
module ec_point_scalar_multiply
   import ecpsm_pkg::*;
#(
   parameter int FIELD_BITS = FIELD_BITS_DEF
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_wdata,
   input  logic                    start,
   output logic                    busy,
   input  logic [WORD_BITS-1:0]    req_scalar_low,
   input  logic [WORD_BITS-1:0]    req_scalar_mid,
   input  logic [TOP_BITS-1:0]     req_scalar_high,
   input  logic [WORD_BITS-1:0]    req_point_x_low,
   input  logic [WORD_BITS-1:0]    req_point_x_mid,
   input  logic [TOP_BITS-1:0]     req_point_x_high,
   input  logic [WORD_BITS-1:0]    req_point_y_low,
   input  logic [WORD_BITS-1:0]    req_point_y_mid,
   input  logic [TOP_BITS-1:0]     req_point_y_high,
   input  logic                    req_point_at_infinity,
   output logic                    rsp_valid,
   output logic [WORD_BITS-1:0]    rsp_result_x_low,
   output logic [WORD_BITS-1:0]    rsp_result_x_mid,
   output logic [TOP_BITS-1:0]     rsp_result_x_high,
   output logic [WORD_BITS-1:0]    rsp_result_y_low,
   output logic [WORD_BITS-1:0]    rsp_result_y_mid,
   output logic [TOP_BITS-1:0]     rsp_result_y_high,
   output logic                    rsp_result_at_infinity
);

   localparam int W = FIELD_BITS;
   localparam logic [W-1:0] ONE = W'(1);

   localparam logic [5:0] S_IDLE  = 6'd0;
   localparam logic [5:0] S_RA    = 6'd1;
   localparam logic [5:0] S_RX    = 6'd2;
   localparam logic [5:0] S_RY    = 6'd3;
   localparam logic [5:0] S_LOOP  = 6'd4;
   localparam logic [5:0] S_ACHK  = 6'd5;
   localparam logic [5:0] S_ANEG  = 6'd6;
   localparam logic [5:0] S_ANCHK = 6'd7;
   localparam logic [5:0] S_A1    = 6'd8;
   localparam logic [5:0] S_A2    = 6'd9;
   localparam logic [5:0] S_A3    = 6'd10;
   localparam logic [5:0] S_A4    = 6'd11;
   localparam logic [5:0] S_A5    = 6'd12;
   localparam logic [5:0] S_A6    = 6'd13;
   localparam logic [5:0] S_A7    = 6'd14;
   localparam logic [5:0] S_A8    = 6'd15;
   localparam logic [5:0] S_A9    = 6'd16;
   localparam logic [5:0] S_A10   = 6'd17;
   localparam logic [5:0] S_NEXT  = 6'd18;
   localparam logic [5:0] S_DCHK  = 6'd19;
   localparam logic [5:0] S_D1    = 6'd20;
   localparam logic [5:0] S_D2    = 6'd21;
   localparam logic [5:0] S_D3    = 6'd22;
   localparam logic [5:0] S_D4    = 6'd23;
   localparam logic [5:0] S_D5    = 6'd24;
   localparam logic [5:0] S_D6    = 6'd25;
   localparam logic [5:0] S_D7    = 6'd26;
   localparam logic [5:0] S_D8    = 6'd27;
   localparam logic [5:0] S_D9    = 6'd28;
   localparam logic [5:0] S_D10   = 6'd29;
   localparam logic [5:0] S_D11   = 6'd30;
   localparam logic [5:0] S_D12   = 6'd31;
   localparam logic [5:0] S_D13   = 6'd32;
   localparam logic [5:0] S_DWR   = 6'd33;
   localparam logic [5:0] S_OUT   = 6'd34;

   localparam logic [2:0] D_A   = 3'd0;
   localparam logic [2:0] D_X1  = 3'd1;
   localparam logic [2:0] D_Y1  = 3'd2;
   localparam logic [2:0] D_T0  = 3'd3;
   localparam logic [2:0] D_T1  = 3'd4;
   localparam logic [2:0] D_T2  = 3'd5;
   localparam logic [2:0] D_SUM = 3'd6;

   logic [WORD_BITS-1:0] mod_lo_ff, mod_mid_ff, a_lo_ff, a_mid_ff;
   logic [TOP_BITS-1:0]  mod_hi_ff, a_hi_ff;
   logic [W-1:0]         mod_w, a_w;

   logic [5:0]   state_ff, state_in;
   logic         issued_ff, issued_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] k_ff, k_in;
   logic [W-1:0] x1_ff, x1_in, y1_ff, y1_in, x2_ff, x2_in, y2_ff, y2_in;
   logic [W-1:0] a_ff, a_in, t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in;
   logic         ainf_ff, ainf_in, sinf_ff, sinf_in, dsum_ff, dsum_in;
   logic [IN_BITS-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic         rinf_ff, rinf_in;

   logic         op_st;
   logic [1:0]   alu_op;
   logic [W-1:0] alu_a, alu_b;
   logic [2:0]   dst;
   logic [5:0]   nxt;

   falu_req_type falu_req;
   logic         falu_done;
   logic [W-1:0] falu_res;

   assign mod_w = W'({mod_hi_ff, mod_mid_ff, mod_lo_ff});
   assign a_w   = W'({a_hi_ff, a_mid_ff, a_lo_ff});

   always_comb begin
      op_st  = 1'b1;
      alu_op = OP_ADD;
      alu_a  = '0;
      alu_b  = '0;
      dst    = D_T0;
      nxt    = S_IDLE;
      unique case (state_ff)
         S_RA:   begin alu_op = OP_MUL; alu_a = ONE;   alu_b = a_ff;  dst = D_A;   nxt = S_RX;    end
         S_RX:   begin alu_op = OP_MUL; alu_a = ONE;   alu_b = x1_ff; dst = D_X1;  nxt = S_RY;    end
         S_RY:   begin alu_op = OP_MUL; alu_a = ONE;   alu_b = y1_ff; dst = D_Y1;  nxt = S_LOOP;  end
         S_ANEG: begin alu_op = OP_SUB; alu_a = '0;    alu_b = y1_ff; dst = D_T0;  nxt = S_ANCHK; end
         S_A1:   begin alu_op = OP_SUB; alu_a = x2_ff; alu_b = x1_ff; dst = D_T0;  nxt = S_A2;    end
         S_A2:   begin alu_op = OP_INV; alu_a = t0_ff;                dst = D_T0;  nxt = S_A3;    end
         S_A3:   begin alu_op = OP_SUB; alu_a = y2_ff; alu_b = y1_ff; dst = D_T1;  nxt = S_A4;    end
         S_A4:   begin alu_op = OP_MUL; alu_a = t0_ff; alu_b = t1_ff; dst = D_T0;  nxt = S_A5;    end
         S_A5:   begin alu_op = OP_MUL; alu_a = t0_ff; alu_b = t0_ff; dst = D_T1;  nxt = S_A6;    end
         S_A6:   begin alu_op = OP_SUB; alu_a = t1_ff; alu_b = x2_ff; dst = D_T1;  nxt = S_A7;    end
         S_A7:   begin alu_op = OP_SUB; alu_a = t1_ff; alu_b = x1_ff; dst = D_T1;  nxt = S_A8;    end
         S_A8:   begin alu_op = OP_SUB; alu_a = x2_ff; alu_b = t1_ff; dst = D_T2;  nxt = S_A9;    end
         S_A9:   begin alu_op = OP_MUL; alu_a = t0_ff; alu_b = t2_ff; dst = D_T2;  nxt = S_A10;   end
         S_A10:  begin alu_op = OP_SUB; alu_a = t2_ff; alu_b = y2_ff; dst = D_SUM; nxt = S_NEXT;  end
         S_D1:   begin alu_op = OP_MUL; alu_a = x1_ff; alu_b = x1_ff; dst = D_T0;  nxt = S_D2;    end
         S_D2:   begin alu_op = OP_ADD; alu_a = t0_ff; alu_b = t0_ff; dst = D_T1;  nxt = S_D3;    end
         S_D3:   begin alu_op = OP_ADD; alu_a = t1_ff; alu_b = t0_ff; dst = D_T1;  nxt = S_D4;    end
         S_D4:   begin alu_op = OP_ADD; alu_a = t1_ff; alu_b = a_ff;  dst = D_T1;  nxt = S_D5;    end
         S_D5:   begin alu_op = OP_ADD; alu_a = y1_ff; alu_b = y1_ff; dst = D_T0;  nxt = S_D6;    end
         S_D6:   begin alu_op = OP_INV; alu_a = t0_ff;                dst = D_T0;  nxt = S_D7;    end
         S_D7:   begin alu_op = OP_MUL; alu_a = t1_ff; alu_b = t0_ff; dst = D_T0;  nxt = S_D8;    end
         S_D8:   begin alu_op = OP_MUL; alu_a = t0_ff; alu_b = t0_ff; dst = D_T1;  nxt = S_D9;    end
         S_D9:   begin alu_op = OP_SUB; alu_a = t1_ff; alu_b = x1_ff; dst = D_T1;  nxt = S_D10;   end
         S_D10:  begin alu_op = OP_SUB; alu_a = t1_ff; alu_b = x1_ff; dst = D_T1;  nxt = S_D11;   end
         S_D11:  begin alu_op = OP_SUB; alu_a = x1_ff; alu_b = t1_ff; dst = D_T2;  nxt = S_D12;   end
         S_D12:  begin alu_op = OP_MUL; alu_a = t0_ff; alu_b = t2_ff; dst = D_T2;  nxt = S_D13;   end
         S_D13:  begin alu_op = OP_SUB; alu_a = t2_ff; alu_b = y1_ff; dst = D_T2;  nxt = S_DWR;   end
         default: op_st = 1'b0;
      endcase
   end

   assign falu_req = '{start: op_st && !issued_ff, op: alu_op};

   ecpsm_falu #(
      .FIELD_BITS (FIELD_BITS)
   ) u_falu (
      .clock   (clock),
      .reset   (reset),
      .req     (falu_req),
      .opa     (alu_a),
      .opb     (alu_b),
      .modulus (mod_w),
      .done    (falu_done),
      .res     (falu_res)
   );

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      rsp_valid_in = 1'b0;
      k_in    = k_ff;
      x1_in   = x1_ff;
      y1_in   = y1_ff;
      x2_in   = x2_ff;
      y2_in   = y2_ff;
      a_in    = a_ff;
      t0_in   = t0_ff;
      t1_in   = t1_ff;
      t2_in   = t2_ff;
      ainf_in = ainf_ff;
      sinf_in = sinf_ff;
      dsum_in = dsum_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      rinf_in = rinf_ff;
      if (op_st) begin
         if (!issued_ff) begin
            issued_in = 1'b1;
         end
         if (falu_done) begin
            issued_in = 1'b0;
            state_in  = nxt;
            unique case (dst)
               D_A:   a_in  = falu_res;
               D_X1:  x1_in = falu_res;
               D_Y1:  y1_in = falu_res;
               D_T0:  t0_in = falu_res;
               D_T1:  t1_in = falu_res;
               D_T2:  t2_in = falu_res;
               D_SUM: begin
                  x2_in   = t1_ff;
                  y2_in   = falu_res;
                  sinf_in = 1'b0;
               end
               default: ;
            endcase
         end
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               sinf_in = 1'b1;
               ainf_in = 1'b0;
               dsum_in = 1'b0;
               k_in    = W'({req_scalar_high, req_scalar_mid, req_scalar_low});
               x1_in   = W'({req_point_x_high, req_point_x_mid, req_point_x_low});
               y1_in   = W'({req_point_y_high, req_point_y_mid, req_point_y_low});
               a_in    = a_w;
               if (mod_w <= ONE || req_point_at_infinity) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_RA;
               end
            end
         end
         S_LOOP: begin
            if (k_ff == '0) begin
               state_in = S_OUT;
            end else if (k_ff[0]) begin
               state_in = S_ACHK;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_ACHK: begin
            priority if (sinf_ff) begin
               x2_in    = x1_ff;
               y2_in    = y1_ff;
               sinf_in  = ainf_ff;
               state_in = S_NEXT;
            end else if (ainf_ff) begin
               state_in = S_NEXT;
            end else if (x2_ff == x1_ff && y2_ff == y1_ff) begin
               dsum_in  = 1'b1;
               state_in = S_DCHK;
            end else begin
               state_in = S_ANEG;
            end
         end
         S_ANCHK: begin
            if (x2_ff == x1_ff && y2_ff == t0_ff) begin
               sinf_in  = 1'b1;
               state_in = S_NEXT;
            end else begin
               state_in = S_A1;
            end
         end
         S_NEXT: begin
            k_in = k_ff >> 1;
            if (k_ff[W-1:1] != '0) begin
               dsum_in  = 1'b0;
               state_in = S_DCHK;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_DCHK: begin
            priority if (!dsum_ff && ainf_ff) begin
               state_in = S_LOOP;
            end else if (y1_ff == '0) begin
               if (dsum_ff) begin
                  sinf_in  = 1'b1;
                  state_in = S_NEXT;
               end else begin
                  ainf_in  = 1'b1;
                  state_in = S_LOOP;
               end
            end else begin
               state_in = S_D1;
            end
         end
         S_DWR: begin
            if (dsum_ff) begin
               x2_in    = t1_ff;
               y2_in    = t2_ff;
               sinf_in  = 1'b0;
               state_in = S_NEXT;
            end else begin
               x1_in    = t1_ff;
               y1_in    = t2_ff;
               state_in = S_LOOP;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rinf_in      = sinf_ff;
            rx_in        = sinf_ff ? '0 : IN_BITS'(x2_ff);
            ry_in        = sinf_ff ? '0 : IN_BITS'(y2_ff);
            state_in     = S_IDLE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mod_lo_ff    <= '0;
         mod_mid_ff   <= '0;
         mod_hi_ff    <= '0;
         a_lo_ff      <= '0;
         a_mid_ff     <= '0;
         a_hi_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_MOD_LOW:  mod_lo_ff  <= csr_wdata;
               REG_MOD_MID:  mod_mid_ff <= csr_wdata;
               REG_MOD_HIGH: mod_hi_ff  <= csr_wdata[TOP_BITS-1:0];
               REG_A_LOW:    a_lo_ff    <= csr_wdata;
               REG_A_MID:    a_mid_ff   <= csr_wdata;
               REG_A_HIGH:   a_hi_ff    <= csr_wdata[TOP_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      x1_ff   <= x1_in;
      y1_ff   <= y1_in;
      x2_ff   <= x2_in;
      y2_ff   <= y2_in;
      a_ff    <= a_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      t2_ff   <= t2_in;
      ainf_ff <= ainf_in;
      sinf_ff <= sinf_in;
      dsum_ff <= dsum_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      rinf_ff <= rinf_in;
   end

   assign busy                   = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_result_x_low       = rx_ff[WORD_BITS-1:0];
   assign rsp_result_x_mid       = rx_ff[2*WORD_BITS-1:WORD_BITS];
   assign rsp_result_x_high      = rx_ff[IN_BITS-1:2*WORD_BITS];
   assign rsp_result_y_low       = ry_ff[WORD_BITS-1:0];
   assign rsp_result_y_mid       = ry_ff[2*WORD_BITS-1:WORD_BITS];
   assign rsp_result_y_high      = ry_ff[IN_BITS-1:2*WORD_BITS];
   assign rsp_result_at_infinity = rinf_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_inf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_at_infinity |->
         rsp_result_x_low == '0 && rsp_result_x_mid == '0 && rsp_result_x_high == '0 &&
         rsp_result_y_low == '0 && rsp_result_y_mid == '0 && rsp_result_y_high == '0)
      else $error("infinity result with nonzero coordinates");

   a_alu_done: assert property (@(posedge clock) disable iff (reset)
      falu_done |-> issued_ff && op_st)
      else $error("field unit done without a pending operation");

endmodule

>>> test/ec_point_scalar_multiply_chk.sv
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply_chk
// Scoreboard for the scalar multiplier: mirrors the CSRs, computes k*P for
// every accepted word with its own affine field arithmetic, compares results.
// ----------------------------------------------------------------------------
module ec_point_scalar_multiply_chk
   import ecpsm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]    csr_wdata,
   input  logic                    start,
   input  logic                    busy,
   input  logic [WORD_BITS-1:0]    req_scalar_low,
   input  logic [WORD_BITS-1:0]    req_scalar_mid,
   input  logic [TOP_BITS-1:0]     req_scalar_high,
   input  logic [WORD_BITS-1:0]    req_point_x_low,
   input  logic [WORD_BITS-1:0]    req_point_x_mid,
   input  logic [TOP_BITS-1:0]     req_point_x_high,
   input  logic [WORD_BITS-1:0]    req_point_y_low,
   input  logic [WORD_BITS-1:0]    req_point_y_mid,
   input  logic [TOP_BITS-1:0]     req_point_y_high,
   input  logic                    req_point_at_infinity,
   input  logic                    rsp_valid,
   input  logic [WORD_BITS-1:0]    rsp_result_x_low,
   input  logic [WORD_BITS-1:0]    rsp_result_x_mid,
   input  logic [TOP_BITS-1:0]     rsp_result_x_high,
   input  logic [WORD_BITS-1:0]    rsp_result_y_low,
   input  logic [WORD_BITS-1:0]    rsp_result_y_mid,
   input  logic [TOP_BITS-1:0]     rsp_result_y_high,
   input  logic                    rsp_result_at_infinity,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = IN_BITS;
   typedef logic [NB-1:0] elem_type;
   typedef struct {
      elem_type x;
      elem_type y;
      logic     inf;
   } point_type;

   elem_type  modulus, coef_a;
   point_type product_q[$];

   function automatic elem_type fe_add(elem_type a, elem_type b, elem_type p);
      logic [NB:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, p}) s = s - {1'b0, p};
      return s[NB-1:0];
   endfunction

   function automatic elem_type fe_sub(elem_type a, elem_type b, elem_type p);
      logic [NB:0] s;
      if (a >= b) return a - b;
      s = {1'b0, a} + {1'b0, p} - {1'b0, b};
      return s[NB-1:0];
   endfunction

   function automatic elem_type fe_mul(elem_type a, elem_type b, elem_type p);
      logic [2*NB-1:0] m;
      m = {{NB{1'b0}}, a} * {{NB{1'b0}}, b};
      m = m % {{NB{1'b0}}, p};
      return m[NB-1:0];
   endfunction

   function automatic elem_type fe_inv(elem_type v, elem_type p);
      elem_type e, r;
      e = p - elem_type'(2);
      r = elem_type'(1);
      for (int i = NB - 1; i >= 0; i--) begin
         r = fe_mul(r, r, p);
         if (e[i]) r = fe_mul(r, v, p);
      end
      return r;
   endfunction

   function automatic point_type pt_double(point_type u, elem_type p, elem_type a);
      point_type r;
      elem_type  x2, rise, s;
      r = '{x: '0, y: '0, inf: 1'b1};
      if (u.inf) return u;
      if (u.y == '0) return r;
      x2   = fe_mul(u.x, u.x, p);
      rise = fe_add(fe_add(fe_add(x2, x2, p), x2, p), a, p);
      s    = fe_mul(rise, fe_inv(fe_add(u.y, u.y, p), p), p);
      r.x  = fe_sub(fe_sub(fe_mul(s, s, p), u.x, p), u.x, p);
      r.y  = fe_sub(fe_mul(s, fe_sub(u.x, r.x, p), p), u.y, p);
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic point_type pt_add(point_type u, point_type v, elem_type p, elem_type a);
      point_type r;
      elem_type  s, ny;
      r = '{x: '0, y: '0, inf: 1'b1};
      if (u.inf) return v;
      if (v.inf) return u;
      if (u.x == v.x && u.y == v.y) return pt_double(u, p, a);
      ny = (v.y == '0) ? v.y : p - v.y;
      if (u.x == v.x && u.y == ny) return r;
      s   = fe_mul(fe_inv(fe_sub(u.x, v.x, p), p), fe_sub(u.y, v.y, p), p);
      r.x = fe_sub(fe_sub(fe_mul(s, s, p), u.x, p), v.x, p);
      r.y = fe_sub(fe_mul(s, fe_sub(u.x, r.x, p), p), u.y, p);
      r.inf = 1'b0;
      return r;
   endfunction

   function automatic point_type scalar_multiply(elem_type k, point_type base, elem_type p,
                                                 elem_type a);
      point_type acc, addend;
      int        top;
      acc = '{x: '0, y: '0, inf: 1'b1};
      top = 0;
      if (p > elem_type'(1) && !base.inf) begin
         addend = '{x: base.x % p, y: base.y % p, inf: 1'b0};
         for (int i = 0; i < NB; i++) if (k[i]) top = i + 1;
         for (int i = 0; i < top; i++) begin
            if (k[i]) acc = pt_add(acc, addend, p, a % p);
            if (i + 1 < top) addend = pt_double(addend, p, a % p);
         end
      end
      if (acc.inf) acc = '{x: '0, y: '0, inf: 1'b1};
      return acc;
   endfunction

   task automatic report_mismatch(string what, elem_type got, elem_type want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      point_type base, want, got;
      if (reset) begin
         modulus    <= '0;
         coef_a     <= '0;
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MOD_LOW:  modulus[63:0]   <= csr_wdata;
               REG_MOD_MID:  modulus[127:64] <= csr_wdata;
               REG_MOD_HIGH: modulus[130:128] <= csr_wdata[2:0];
               REG_A_LOW:    coef_a[63:0]    <= csr_wdata;
               REG_A_MID:    coef_a[127:64]  <= csr_wdata;
               REG_A_HIGH:   coef_a[130:128] <= csr_wdata[2:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            base.x   = {req_point_x_high, req_point_x_mid, req_point_x_low};
            base.y   = {req_point_y_high, req_point_y_mid, req_point_y_low};
            base.inf = req_point_at_infinity;
            product_q.insert(product_q.size(), scalar_multiply(
               {req_scalar_high, req_scalar_mid, req_scalar_low}, base, modulus, coef_a));
         end
         if (rsp_valid) begin
            got.x   = {rsp_result_x_high, rsp_result_x_mid, rsp_result_x_low};
            got.y   = {rsp_result_y_high, rsp_result_y_mid, rsp_result_y_low};
            got.inf = rsp_result_at_infinity;
            if (product_q.size() == 0) begin
               report_mismatch("unexpected word", got.x, '0);
            end else begin
               want = product_q.pop_front();
               if (got.x != want.x) report_mismatch("x", got.x, want.x);
               if (got.y != want.y) report_mismatch("y", got.y, want.y);
               if (got.inf != want.inf)
                  report_mismatch("at_infinity", elem_type'(got.inf), elem_type'(want.inf));
            end
         end
      end
      pending <= product_q.size();
   end
endmodule

>>> test/ec_point_scalar_multiply_tb.sv
// ----------------------------------------------------------------------------
// ec_point_scalar_multiply_tb
// Drives k*P words through several modulus and curve settings (zero, one,
// two, small, all ones, random) with directed corners and mostly short random
// scalars; the checker module predicts and compares every result word.
// ----------------------------------------------------------------------------
module ec_point_scalar_multiply_tb
   import ecpsm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         NB         = IN_BITS;
   localparam longint     IDLE_LIMIT = 80_000_000;
   localparam logic [NB-1:0] ALL_ONES = '1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [WORD_BITS-1:0]    csr_wdata = '0;
   logic                    start = 1'b0;
   logic                    busy;
   logic [NB-1:0]           scalar = '0, px = '0, py = '0;
   logic                    pinf = 1'b0;
   logic                    rsp_valid, rsp_result_at_infinity;
   logic [WORD_BITS-1:0]    rx_low, rx_mid, ry_low, ry_mid;
   logic [TOP_BITS-1:0]     rx_high, ry_high;
   int                      fail_count, pending;
   longint                  quiet_cycles = 0;
   bit                      no_gaps = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   ec_point_scalar_multiply DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .start(start), .busy(busy),
      .req_scalar_low(scalar[63:0]), .req_scalar_mid(scalar[127:64]),
      .req_scalar_high(scalar[130:128]),
      .req_point_x_low(px[63:0]), .req_point_x_mid(px[127:64]),
      .req_point_x_high(px[130:128]),
      .req_point_y_low(py[63:0]), .req_point_y_mid(py[127:64]),
      .req_point_y_high(py[130:128]),
      .req_point_at_infinity(pinf),
      .rsp_valid(rsp_valid),
      .rsp_result_x_low(rx_low), .rsp_result_x_mid(rx_mid), .rsp_result_x_high(rx_high),
      .rsp_result_y_low(ry_low), .rsp_result_y_mid(ry_mid), .rsp_result_y_high(ry_high),
      .rsp_result_at_infinity(rsp_result_at_infinity)
   );

   ec_point_scalar_multiply_chk CHK (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .start(start), .busy(busy),
      .req_scalar_low(scalar[63:0]), .req_scalar_mid(scalar[127:64]),
      .req_scalar_high(scalar[130:128]),
      .req_point_x_low(px[63:0]), .req_point_x_mid(px[127:64]),
      .req_point_x_high(px[130:128]),
      .req_point_y_low(py[63:0]), .req_point_y_mid(py[127:64]),
      .req_point_y_high(py[130:128]),
      .req_point_at_infinity(pinf),
      .rsp_valid(rsp_valid),
      .rsp_result_x_low(rx_low), .rsp_result_x_mid(rx_mid), .rsp_result_x_high(rx_high),
      .rsp_result_y_low(ry_low), .rsp_result_y_mid(ry_mid), .rsp_result_y_high(ry_high),
      .rsp_result_at_infinity(rsp_result_at_infinity),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("ec_point_scalar_multiply_tb: errors");
         $finish;
      end
   end

   function automatic logic [NB-1:0] rand_elem();
      return NB'({$urandom, $urandom, $urandom, $urandom, $urandom});
   endfunction

   function automatic logic [NB-1:0] rand_scalar(int nbits);
      logic [NB-1:0] k;
      k = rand_elem();
      if (nbits == 0 || nbits >= NB) return k;
      k = k & ((NB'(1) << nbits) - NB'(1));
      k[nbits-1] = 1'b1;
      return k;
   endfunction

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [WORD_BITS-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
   endtask

   task automatic load_curve(logic [NB-1:0] p, logic [NB-1:0] a);
      write_csr(REG_MOD_LOW, p[63:0]);
      write_csr(REG_MOD_MID, p[127:64]);
      write_csr(REG_MOD_HIGH, {61'd0, p[130:128]} | {$urandom, 32'd0} & 64'hffff_fff8_0000_0000);
      write_csr(REG_A_LOW, a[63:0]);
      write_csr(REG_A_MID, a[127:64]);
      write_csr(REG_A_HIGH, {61'd0, a[130:128]});
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send(logic [NB-1:0] k, logic [NB-1:0] x, logic [NB-1:0] y, logic inf);
      if (!no_gaps && $urandom_range(0, 99) < 32) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            start = 1'b0;
         end
      end
      @(negedge clock);
      scalar = k;
      px     = x;
      py     = y;
      pinf   = inf;
      start  = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_random(int count, int max_bits);
      for (int n = 0; n < count; n++) begin
         send(rand_scalar(max_bits == 0 ? 0 : $urandom_range(1, max_bits)),
              rand_elem(), rand_elem(), $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      logic [NB-1:0] p, x;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // modulus zero after reset: every result is infinity
      send(ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
      send('0, '0, '0, 1'b0);
      send_random(12, 0);
      drain();

      load_curve(NB'(1), ALL_ONES);
      send(ALL_ONES, '0, ALL_ONES, 1'b1);
      send_random(12, 0);
      drain();

      load_curve(NB'(2), NB'(1));
      send(NB'(1), NB'(1), NB'(1), 1'b0);
      send(NB'(2), NB'(1), NB'(1), 1'b0);
      send(NB'(3), NB'(1), NB'(0), 1'b0);
      send_random(6, 3);
      drain();

      load_curve(NB'(97), NB'(2));
      send('0, NB'(3), NB'(6), 1'b0);
      send(NB'(1), NB'(3), NB'(6), 1'b1);
      send(NB'(1), NB'(3 + 97), NB'(6 + 194), 1'b0);
      send(NB'(2), NB'(3), NB'(6), 1'b0);
      send(NB'(2), NB'(5), NB'(0), 1'b0);
      send(NB'(3), NB'(3), NB'(6), 1'b0);
      send(NB'(7), NB'(0), NB'(0), 1'b0);
      send(NB'(6), NB'(11), NB'(40), 1'b0);
      no_gaps = 1'b1;
      send_random(15, 4);
      no_gaps = 1'b0;
      drain();

      load_curve(ALL_ONES, ALL_ONES);
      send(ALL_ONES, ALL_ONES - 1, ALL_ONES, 1'b0);
      send(NB'(2), ALL_ONES, NB'(5), 1'b0);
      send_random(15, 4);
      drain();

      p = rand_elem() | (NB'(1) << (NB - 1));
      load_curve(p, rand_elem());
      x = rand_elem();
      send(NB'(5), x, rand_elem(), 1'b0);
      send_random(20, 5);
      drain();

      if (fail_count == 0) begin
         $display("ec_point_scalar_multiply_tb: clean");
      end else begin
         $display("ec_point_scalar_multiply_tb: errors");
      end
      $finish;
   end
endmodule
